/* src/gff_pkg.sv */
package gff_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned GAIN_BITS = 24;

  localparam int unsigned ID_W     = 8;
  localparam int unsigned COORD_W  = 32;
  localparam int unsigned LAT_W    = 31;
  localparam int unsigned ACC_IN_W = 32;

  localparam int unsigned EST_W    = COORD_W + FRAC_BITS;
  localparam int unsigned GAIN_W   = GAIN_BITS + 1;
  localparam int unsigned MUL_LO_W = 32;
  localparam int unsigned CNT_W    = $clog2(GAIN_BITS);

  localparam logic [ID_W-1:0] MSG_POS = 8'd2;
  localparam logic [ID_W-1:0] MSG_PVT = 8'd7;

  localparam logic [GAIN_W-1:0] G_ONE  = {1'b1, {GAIN_BITS{1'b0}}};
  localparam logic [GAIN_W-1:0] G_HALF = {2'b01, {(GAIN_BITS - 1){1'b0}}};
  localparam logic [EST_W:0]    F_HALF = {{(EST_W - FRAC_BITS + 1){1'b0}}, 1'b1,
                                          {(FRAC_BITS - 1){1'b0}}};

  typedef enum logic [1:0] {
    OP_DIV = 2'd1,
    OP_MUL = 2'd2
  } op_e;

  typedef struct packed {
    logic start;
    op_e  op;
  } unit_req_t;

endpackage

/* src/gnss_fix_fusion_top.sv */
// a first fix goes straight to the output step; a later fix first runs
// two 24-step restoring divisions and five two-pass multiplications
// in the one shared arithmetic unit
// one fix at a time, as the input stalls until the sequencer is back in idle; a stalled
// output holds the sequencer and the input
// reset: asynchronous, clears the estimate, the init flag and the output valid
module gnss_fix_fusion_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic        [gff_pkg::ID_W-1:0]      msg_id_i,
  input  logic signed [gff_pkg::COORD_W-1:0]   lon_in_i,
  input  logic signed [gff_pkg::LAT_W-1:0]     lat_in_i,
  input  logic signed [gff_pkg::COORD_W-1:0]   height_in_i,
  input  logic        [gff_pkg::ACC_IN_W-1:0]  h_acc_in_i,
  input  logic        [gff_pkg::ACC_IN_W-1:0]  v_acc_in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [gff_pkg::COORD_W-1:0]   fused_lon_o,
  output logic signed [gff_pkg::LAT_W-1:0]     fused_lat_o,
  output logic signed [gff_pkg::COORD_W-1:0]   fused_height_o,
  output logic        [gff_pkg::ACC_IN_W-1:0]  fused_h_acc_o,
  output logic        [gff_pkg::ACC_IN_W-1:0]  fused_v_acc_o,
  output logic                                 first_fix_o
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DIV_V    = 9'b000000010,
    S_MUL_HGT  = 9'b000000100,
    S_MUL_VACC = 9'b000001000,
    S_DIV_H    = 9'b000010000,
    S_MUL_LAT  = 9'b000100000,
    S_MUL_LON  = 9'b001000000,
    S_MUL_HACC = 9'b010000000,
    S_OUT      = 9'b100000000
  } state_e;

  localparam int unsigned EW = gff_pkg::EST_W;
  localparam int unsigned FB = gff_pkg::FRAC_BITS;

  state_e                         state_q;
  logic                           busy_q;
  logic                           init_q;
  logic                           first_q;
  logic                           out_valid_q;
  logic [gff_pkg::GAIN_W-1:0]     gain_q;
  logic [EW-1:0]                  est_lon_q;
  logic [EW-1:0]                  est_lat_q;
  logic [EW-1:0]                  est_hgt_q;
  logic [EW-1:0]                  est_hacc_q;
  logic [EW-1:0]                  est_vacc_q;
  logic [EW-1:0]                  lon_q;
  logic [EW-1:0]                  lat_q;
  logic [EW-1:0]                  hgt_q;
  logic [EW-1:0]                  hacc_q;
  logic [EW-1:0]                  vacc_q;
  logic [gff_pkg::COORD_W-1:0]    o_lon_q;
  logic [gff_pkg::LAT_W-1:0]      o_lat_q;
  logic [gff_pkg::COORD_W-1:0]    o_hgt_q;
  logic [gff_pkg::ACC_IN_W-1:0]   o_hacc_q;
  logic [gff_pkg::ACC_IN_W-1:0]   o_vacc_q;
  logic                           o_first_q;

  logic [EW-1:0]                  lon_ext;
  logic [EW-1:0]                  lat_ext;
  logic [EW-1:0]                  hgt_ext;
  logic [EW-1:0]                  hacc_ext;
  logic [EW-1:0]                  vacc_ext;
  logic                           id_ok;
  logic                           op_state;
  logic                           out_free;
  logic [EW-1:0]                  est_sel;
  logic [EW-1:0]                  meas_sel;
  logic [EW:0]                    diff;
  logic [EW:0]                    diff_abs;
  logic                           diff_neg;
  logic [EW-1:0]                  est_upd;
  logic [EW:0]                    rnd_lon;
  logic [EW:0]                    rnd_lat;
  logic [EW:0]                    rnd_hgt;
  logic [EW:0]                    rnd_hacc;
  logic [EW:0]                    rnd_vacc;

  gff_pkg::unit_req_t             unit_req;
  logic [EW-1:0]                  unit_opa;
  logic [EW-1:0]                  unit_opb;
  logic [gff_pkg::GAIN_W-1:0]     unit_f;
  logic [EW-1:0]                  unit_res;
  logic                           unit_done;

  assign lon_ext  = {lon_in_i, {FB{1'b0}}};
  assign lat_ext  = {{(gff_pkg::COORD_W - gff_pkg::LAT_W){lat_in_i[gff_pkg::LAT_W-1]}},
                     lat_in_i, {FB{1'b0}}};
  assign hgt_ext  = {height_in_i, {FB{1'b0}}};
  assign hacc_ext = {h_acc_in_i, {FB{1'b0}}};
  assign vacc_ext = {v_acc_in_i, {FB{1'b0}}};

  always_comb begin
    id_ok = msg_id_i inside {gff_pkg::MSG_POS, gff_pkg::MSG_PVT};
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign op_state   = (state_q != S_IDLE) && (state_q != S_OUT);

  // measurement and estimate for the blend step
  always_comb begin
    case (state_q)
      S_MUL_HGT: begin
        est_sel  = est_hgt_q;
        meas_sel = hgt_q;
      end
      S_MUL_LAT: begin
        est_sel  = est_lat_q;
        meas_sel = lat_q;
      end
      default: begin
        est_sel  = est_lon_q;
        meas_sel = lon_q;
      end
    endcase
  end

  assign diff     = {meas_sel[EW-1], meas_sel} - {est_sel[EW-1], est_sel};
  assign diff_neg = diff[EW];
  assign diff_abs = diff_neg ? (~diff + 1'b1) : diff;
  assign est_upd  = diff_neg ? (est_sel - unit_res) : (est_sel + unit_res);

  always_comb begin
    unit_req.start = op_state && !busy_q;
    unit_req.op    = gff_pkg::OP_MUL;
    unit_opa       = diff_abs[EW-1:0];
    unit_opb       = '0;
    unit_f         = gain_q;
    case (state_q)
      S_DIV_V: begin
        unit_req.op = gff_pkg::OP_DIV;
        unit_opa    = est_vacc_q;
        unit_opb    = vacc_q;
      end
      S_DIV_H: begin
        unit_req.op = gff_pkg::OP_DIV;
        unit_opa    = est_hacc_q;
        unit_opb    = hacc_q;
      end
      S_MUL_VACC: begin
        unit_opa = est_vacc_q;
        unit_f   = gff_pkg::G_ONE - gain_q;
      end
      S_MUL_HACC: begin
        unit_opa = est_hacc_q;
        unit_f   = gff_pkg::G_ONE - gain_q;
      end
      default: begin
      end
    endcase
  end

  gff_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (unit_req),
    .opa_i  (unit_opa),
    .opb_i  (unit_opb),
    .f_i    (unit_f),
    .res_o  (unit_res),
    .done_o (unit_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      busy_q      <= 1'b0;
      init_q      <= 1'b0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
      gain_q      <= '0;
      est_lon_q   <= '0;
      est_lat_q   <= '0;
      est_hgt_q   <= '0;
      est_hacc_q  <= '0;
      est_vacc_q  <= '0;
    end else begin
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && id_ok) begin
            if (!init_q) begin
              init_q     <= 1'b1;
              first_q    <= 1'b1;
              est_lon_q  <= lon_ext;
              est_lat_q  <= lat_ext;
              est_hgt_q  <= hgt_ext;
              est_hacc_q <= hacc_ext;
              est_vacc_q <= vacc_ext;
              state_q    <= S_OUT;
            end else begin
              first_q <= 1'b0;
              state_q <= S_DIV_V;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          if (!busy_q) begin
            busy_q <= 1'b1;
          end else if (unit_done) begin
            busy_q <= 1'b0;
            case (state_q)
              S_DIV_V: begin
                gain_q  <= unit_res[gff_pkg::GAIN_W-1:0];
                state_q <= S_MUL_HGT;
              end
              S_MUL_HGT: begin
                est_hgt_q <= est_upd;
                state_q   <= S_MUL_VACC;
              end
              S_MUL_VACC: begin
                est_vacc_q <= unit_res;
                state_q    <= S_DIV_H;
              end
              S_DIV_H: begin
                gain_q  <= unit_res[gff_pkg::GAIN_W-1:0];
                state_q <= S_MUL_LAT;
              end
              S_MUL_LAT: begin
                est_lat_q <= est_upd;
                state_q   <= S_MUL_LON;
              end
              S_MUL_LON: begin
                est_lon_q <= est_upd;
                state_q   <= S_MUL_HACC;
              end
              S_MUL_HACC: begin
                est_hacc_q <= unit_res;
                state_q    <= S_OUT;
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
      endcase
    end
  end

  // round to nearest, halves upward
  assign rnd_lon  = {est_lon_q[EW-1], est_lon_q} + gff_pkg::F_HALF;
  assign rnd_lat  = {est_lat_q[EW-1], est_lat_q} + gff_pkg::F_HALF;
  assign rnd_hgt  = {est_hgt_q[EW-1], est_hgt_q} + gff_pkg::F_HALF;
  assign rnd_hacc = {1'b0, est_hacc_q} + gff_pkg::F_HALF;
  assign rnd_vacc = {1'b0, est_vacc_q} + gff_pkg::F_HALF;

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      lon_q  <= lon_ext;
      lat_q  <= lat_ext;
      hgt_q  <= hgt_ext;
      hacc_q <= hacc_ext;
      vacc_q <= vacc_ext;
    end
    if (state_q == S_OUT && out_free) begin
      o_lon_q   <= rnd_lon[FB +: gff_pkg::COORD_W];
      o_lat_q   <= rnd_lat[FB +: gff_pkg::LAT_W];
      o_hgt_q   <= rnd_hgt[FB +: gff_pkg::COORD_W];
      o_hacc_q  <= rnd_hacc[FB +: gff_pkg::ACC_IN_W];
      o_vacc_q  <= rnd_vacc[FB +: gff_pkg::ACC_IN_W];
      o_first_q <= first_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign fused_lon_o    = o_lon_q;
  assign fused_lat_o    = o_lat_q;
  assign fused_height_o = o_hgt_q;
  assign fused_h_acc_o  = o_hacc_q;
  assign fused_v_acc_o  = o_vacc_q;
  assign first_fix_o    = o_first_q;

  a_done_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_done |-> busy_q)
    else $error("unit result without a pending request");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_OUT))
    else $error("output valid raised outside the output step");

  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && unit_done && (state_q == S_DIV_V || state_q == S_DIV_H))
      |-> (unit_res <= EW'(gff_pkg::G_ONE)))
    else $error("gain above one");

  a_vacc_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && unit_done && state_q == S_MUL_VACC)
      |=> (est_vacc_q <= $past(est_vacc_q)))
    else $error("vertical accuracy grew on update");

endmodule

/* src/gff_unit.sv */
module gff_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  gff_pkg::unit_req_t              req_i,
  input  logic [gff_pkg::EST_W-1:0]       opa_i,
  input  logic [gff_pkg::EST_W-1:0]       opb_i,
  input  logic [gff_pkg::GAIN_W-1:0]      f_i,
  output logic [gff_pkg::EST_W-1:0]       res_o,
  output logic                            done_o
);

  localparam int unsigned D_W    = gff_pkg::EST_W + 1;
  localparam int unsigned R_W    = gff_pkg::EST_W + 2;
  localparam int unsigned PROD_W = gff_pkg::MUL_LO_W + gff_pkg::GAIN_W;
  localparam int unsigned SUM_W  = gff_pkg::EST_W + gff_pkg::GAIN_BITS + 1;
  localparam int unsigned HI_W   = gff_pkg::EST_W - gff_pkg::MUL_LO_W;

  typedef enum logic [3:0] {
    U_IDLE = 4'b0001,
    U_DIV  = 4'b0010,
    U_MUL1 = 4'b0100,
    U_MUL2 = 4'b1000
  } ustate_e;

  ustate_e                        state_q;
  logic                           done_q;
  logic                           done_d;
  logic [D_W-1:0]                 d_q;
  logic [R_W-1:0]                 r_q;
  logic [gff_pkg::GAIN_BITS-1:0]  q_q;
  logic [gff_pkg::CNT_W-1:0]      cnt_q;
  logic [gff_pkg::EST_W-1:0]      mag_q;
  logic [gff_pkg::GAIN_W-1:0]     f_q;
  logic [PROD_W-1:0]              prod_q;
  logic [SUM_W-1:0]               acc_q;
  logic [gff_pkg::EST_W-1:0]      res_q;

  logic [D_W-1:0]                 d_sum;
  logic [R_W-1:0]                 r_sh;
  logic                           r_ge;
  logic [R_W-1:0]                 r_nx;
  logic [gff_pkg::GAIN_BITS-1:0]  q_nx;
  logic [gff_pkg::MUL_LO_W-1:0]   mul_a;
  logic [gff_pkg::GAIN_W-1:0]     mul_f;
  logic [PROD_W-1:0]              prod;
  logic [SUM_W-1:0]               acc_fin;

  assign d_sum   = {1'b0, opa_i} + {1'b0, opb_i};
  assign r_sh    = {r_q[R_W-2:0], 1'b0};
  assign r_ge    = r_sh >= R_W'(d_q);
  assign r_nx    = r_ge ? (r_sh - R_W'(d_q)) : r_sh;
  assign q_nx    = {q_q[gff_pkg::GAIN_BITS-2:0], r_ge};
  assign mul_a   = (state_q == U_MUL1)
                   ? {{(gff_pkg::MUL_LO_W - HI_W){1'b0}},
                      mag_q[gff_pkg::EST_W-1:gff_pkg::MUL_LO_W]}
                   : opa_i[gff_pkg::MUL_LO_W-1:0];
  assign mul_f   = (state_q == U_MUL1) ? f_q : f_i;
  assign prod    = PROD_W'(mul_a) * PROD_W'(mul_f);
  assign acc_fin = acc_q + (SUM_W'(prod_q) << gff_pkg::MUL_LO_W);

  always_comb begin
    done_d = 1'b0;
    case (state_q)
      U_IDLE: begin
        if (req_i.start) begin
          if (req_i.op == gff_pkg::OP_DIV) begin
            done_d = (d_sum == '0) || (opb_i == '0);
          end else begin
            done_d = (f_i >= gff_pkg::G_ONE);
          end
        end
      end
      U_DIV: begin
        done_d = (cnt_q == gff_pkg::CNT_W'(gff_pkg::GAIN_BITS - 1));
      end
      U_MUL2: begin
        done_d = 1'b1;
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= done_d;
      case (state_q)
        U_IDLE: begin
          if (req_i.start) begin
            if (req_i.op == gff_pkg::OP_DIV) begin
              if (d_sum != '0 && opb_i != '0) begin
                state_q <= U_DIV;
              end
            end else begin
              if (f_i < gff_pkg::G_ONE) begin
                state_q <= U_MUL1;
              end
            end
          end
        end
        U_DIV: begin
          if (cnt_q == gff_pkg::CNT_W'(gff_pkg::GAIN_BITS - 1)) begin
            state_q <= U_IDLE;
          end
        end
        U_MUL1: begin
          state_q <= U_MUL2;
        end
        U_MUL2: begin
          state_q <= U_IDLE;
        end
        default: begin
          state_q <= U_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      U_IDLE: begin
        if (req_i.start) begin
          if (req_i.op == gff_pkg::OP_DIV) begin
            if (d_sum == '0) begin
              res_q <= '0;
            end else if (opb_i == '0) begin
              res_q <= gff_pkg::EST_W'(gff_pkg::G_ONE);
            end
            d_q   <= d_sum;
            r_q   <= R_W'(opa_i);
            q_q   <= '0;
            cnt_q <= '0;
          end else begin
            if (f_i >= gff_pkg::G_ONE) begin
              res_q <= opa_i;
            end
            mag_q  <= opa_i;
            f_q    <= f_i;
            prod_q <= prod;
          end
        end
      end
      U_DIV: begin
        r_q   <= r_nx;
        q_q   <= q_nx;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == gff_pkg::CNT_W'(gff_pkg::GAIN_BITS - 1)) begin
          res_q <= gff_pkg::EST_W'(q_nx);
        end
      end
      U_MUL1: begin
        acc_q  <= SUM_W'(prod_q) + SUM_W'(gff_pkg::G_HALF);
        prod_q <= prod;
      end
      U_MUL2: begin
        res_q <= acc_fin[gff_pkg::GAIN_BITS +: gff_pkg::EST_W];
      end
      default: begin
      end
    endcase
  end

  assign res_o  = res_q;
  assign done_o = done_q;

endmodule

/* dv/tb_gnss_fix_fusion_top.sv */
module tb_gnss_fix_fusion_top;
  import gff_pkg::*;

  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned QUIET_LIMIT     = 3000;
  localparam int unsigned DRAIN_CYCLES    = 120;
  localparam int unsigned PROD_W          = 64 + GAIN_W;

  localparam logic [ID_W-1:0]            ID_MIN  = '0;
  localparam logic [ID_W-1:0]            ID_MAX  = '1;
  localparam logic signed [COORD_W-1:0]  LON_MAX = 32'sd1800000000;
  localparam logic signed [COORD_W-1:0]  LON_MIN = -32'sd1800000000;
  localparam logic signed [LAT_W-1:0]    LAT_MAX = 31'sd900000000;
  localparam logic signed [LAT_W-1:0]    LAT_MIN = -31'sd900000000;
  localparam logic signed [COORD_W-1:0]  HGT_MAX = 32'sh7fff_ffff;
  localparam logic signed [COORD_W-1:0]  HGT_MIN = 32'sh8000_0000;
  localparam logic [ACC_IN_W-1:0]        ACC_MAX = '1;

  typedef struct packed {
    logic        [ID_W-1:0]     id;
    logic signed [COORD_W-1:0]  lon;
    logic signed [LAT_W-1:0]    lat;
    logic signed [COORD_W-1:0]  height;
    logic        [ACC_IN_W-1:0] h_acc;
    logic        [ACC_IN_W-1:0] v_acc;
  } fix_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  lon;
    logic signed [LAT_W-1:0]    lat;
    logic signed [COORD_W-1:0]  height;
    logic        [ACC_IN_W-1:0] h_acc;
    logic        [ACC_IN_W-1:0] v_acc;
    logic                       first;
  } fused_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic        [ID_W-1:0]     msg_id_i;
  logic signed [COORD_W-1:0]  lon_in_i;
  logic signed [LAT_W-1:0]    lat_in_i;
  logic signed [COORD_W-1:0]  height_in_i;
  logic        [ACC_IN_W-1:0] h_acc_in_i;
  logic        [ACC_IN_W-1:0] v_acc_in_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic signed [COORD_W-1:0]  fused_lon_o;
  logic signed [LAT_W-1:0]    fused_lat_o;
  logic signed [COORD_W-1:0]  fused_height_o;
  logic        [ACC_IN_W-1:0] fused_h_acc_o;
  logic        [ACC_IN_W-1:0] fused_v_acc_o;
  logic                       first_fix_o;

  // running estimate, FRAC_BITS fraction bits
  logic                    fix_loaded = 1'b0;
  logic signed [EST_W-1:0] est_lon    = '0;
  logic signed [EST_W-1:0] est_lat    = '0;
  logic signed [EST_W-1:0] est_height = '0;
  logic        [EST_W-1:0] est_h_acc  = '0;
  logic        [EST_W-1:0] est_v_acc  = '0;

  fused_t      pending_fusions[$];
  int unsigned mismatches = 0;
  bit          steady_flow = 1'b0;
  int unsigned burst_reqs = 0;
  longint      track_lon;
  longint      track_lat;
  longint      track_height;

  gnss_fix_fusion_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .msg_id_i       (msg_id_i),
    .lon_in_i       (lon_in_i),
    .lat_in_i       (lat_in_i),
    .height_in_i    (height_in_i),
    .h_acc_in_i     (h_acc_in_i),
    .v_acc_in_i     (v_acc_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .fused_lon_o    (fused_lon_o),
    .fused_lat_o    (fused_lat_o),
    .fused_height_o (fused_height_o),
    .fused_h_acc_o  (fused_h_acc_o),
    .fused_v_acc_o  (fused_v_acc_o),
    .first_fix_o    (first_fix_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // floor(stored * 2^GAIN_BITS / (stored + new))
  function automatic logic [GAIN_W-1:0] fusion_gain(input logic [EST_W-1:0] stored,
                                                    input logic [EST_W-1:0] meas_acc);
    logic [EST_W:0]           total;
    logic [EST_W+GAIN_BITS:0] quot;
    total = {1'b0, stored} + {1'b0, meas_acc};
    if (total == '0) return '0;
    if (meas_acc == '0) return G_ONE;
    quot = {1'b0, stored, {GAIN_BITS{1'b0}}} / {{GAIN_BITS{1'b0}}, total};
    return quot[GAIN_W-1:0];
  endfunction

  // mag * g / 2^GAIN_BITS, halves up
  function automatic logic [63:0] scale_by_gain(input logic [63:0] mag,
                                                input logic [GAIN_W-1:0] g);
    logic [PROD_W-1:0] prod;
    prod = {{GAIN_W{1'b0}}, mag} * {64'b0, g} + {64'b0, G_HALF};
    return prod[GAIN_BITS +: 64];
  endfunction

  // step rounded with halves away from zero
  function automatic logic signed [63:0] pull_toward(input logic signed [63:0] est,
                                                    input logic signed [63:0] meas,
                                                    input logic [GAIN_W-1:0] g);
    logic signed [63:0] diff;
    diff = meas - est;
    if (!diff[63]) return est + $signed(scale_by_gain(diff, g));
    return est - $signed(scale_by_gain(-diff, g));
  endfunction

  function automatic logic [63:0] round_coord(input logic signed [63:0] v);
    logic signed [63:0] x;
    x = v + $signed({{(63 - EST_W){1'b0}}, F_HALF});
    return x >>> FRAC_BITS;
  endfunction

  function automatic logic [ACC_IN_W-1:0] round_acc(input logic [EST_W-1:0] v);
    logic [EST_W:0] x;
    x = {1'b0, v} + F_HALF;
    return x[FRAC_BITS +: ACC_IN_W];
  endfunction

  function automatic void fuse_fix(input fix_t f);
    logic signed [63:0] lon_m, lat_m, hgt_m;
    logic [EST_W-1:0]   h_acc_m, v_acc_m;
    logic [GAIN_W-1:0]  g;
    logic [63:0]        lon_r, lat_r, hgt_r;
    fused_t             r;
    if (f.id != MSG_POS && f.id != MSG_PVT) return;
    lon_m   = 64'($signed(f.lon)) <<< FRAC_BITS;
    lat_m   = 64'($signed(f.lat)) <<< FRAC_BITS;
    hgt_m   = 64'($signed(f.height)) <<< FRAC_BITS;
    h_acc_m = {f.h_acc, {FRAC_BITS{1'b0}}};
    v_acc_m = {f.v_acc, {FRAC_BITS{1'b0}}};
    r.first = ~fix_loaded;
    if (!fix_loaded) begin
      fix_loaded = 1'b1;
      est_lon    = EST_W'(lon_m);
      est_lat    = EST_W'(lat_m);
      est_height = EST_W'(hgt_m);
      est_h_acc  = h_acc_m;
      est_v_acc  = v_acc_m;
    end else begin
      g          = fusion_gain(est_v_acc, v_acc_m);
      est_height = EST_W'(pull_toward(64'(est_height), hgt_m, g));
      est_v_acc  = EST_W'(scale_by_gain(64'(est_v_acc), G_ONE - g));
      g          = fusion_gain(est_h_acc, h_acc_m);
      est_lat    = EST_W'(pull_toward(64'(est_lat), lat_m, g));
      est_lon    = EST_W'(pull_toward(64'(est_lon), lon_m, g));
      est_h_acc  = EST_W'(scale_by_gain(64'(est_h_acc), G_ONE - g));
    end
    lon_r    = round_coord(64'(est_lon));
    lat_r    = round_coord(64'(est_lat));
    hgt_r    = round_coord(64'(est_height));
    r.lon    = lon_r[COORD_W-1:0];
    r.lat    = lat_r[LAT_W-1:0];
    r.height = hgt_r[COORD_W-1:0];
    r.h_acc  = round_acc(est_h_acc);
    r.v_acc  = round_acc(est_v_acc);
    pending_fusions.push_back(r);
  endfunction

  function automatic void check_field(input string name, input logic signed [63:0] want,
                                      input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    fused_t want;
    if (in_valid_i && !in_stall_o)
      fuse_fix({msg_id_i, lon_in_i, lat_in_i, height_in_i, h_acc_in_i, v_acc_in_i});
    if (out_valid_o && !out_stall_i) begin
      if (pending_fusions.size() == 0) begin
        $error("fused result with no fix waiting: lon %0d lat %0d", fused_lon_o, fused_lat_o);
        mismatches++;
      end else begin
        want = pending_fusions.pop_front();
        check_field("fused_lon", 64'($signed(want.lon)), 64'(fused_lon_o));
        check_field("fused_lat", 64'($signed(want.lat)), 64'(fused_lat_o));
        check_field("fused_height", 64'($signed(want.height)), 64'(fused_height_o));
        check_field("fused_h_acc", 64'(want.h_acc), 64'(fused_h_acc_o));
        check_field("fused_v_acc", 64'(want.v_acc), 64'(fused_v_acc_o));
        check_field("first_fix", 64'(want.first), 64'(first_fix_o));
      end
    end
  end

  // output side: random stalls plus requested long hold-offs
  initial begin
    int unsigned seen;
    int unsigned hold_left;
    seen        = 0;
    hold_left   = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (burst_reqs != seen) begin
        seen      = burst_reqs;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= !steady_flow && ($urandom_range(99) < 12);
      end
    end
  end

  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle = 0;
      else idle++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic fix_t make_fix(input logic [ID_W-1:0] id,
                                    input logic signed [COORD_W-1:0] lon,
                                    input logic signed [LAT_W-1:0] lat,
                                    input logic signed [COORD_W-1:0] height,
                                    input logic [ACC_IN_W-1:0] h_acc,
                                    input logic [ACC_IN_W-1:0] v_acc);
    fix_t f;
    f.id     = id;
    f.lon    = lon;
    f.lat    = lat;
    f.height = height;
    f.h_acc  = h_acc;
    f.v_acc  = v_acc;
    return f;
  endfunction

  function automatic logic [ACC_IN_W-1:0] random_acc();
    int unsigned pick;
    logic [ACC_IN_W-1:0] a;
    pick = $urandom_range(99);
    if (pick < 50) return ACC_IN_W'($urandom_range(5000, 1));
    if (pick < 80) return ACC_IN_W'($urandom_range(2000000, 1));
    a = $urandom();
    if (a == '0) a = 1;
    return a;
  endfunction

  // mostly a wandering receiver position, some far jumps and raw bit patterns
  function automatic fix_t random_fix();
    fix_t f;
    int unsigned pick;
    pick = $urandom_range(99);
    f.id = (pick < 85) ? (pick[0] ? MSG_POS : MSG_PVT) : ID_W'($urandom());
    pick = $urandom_range(9);
    track_lon    = track_lon + longint'($urandom_range(200)) - 100;
    track_lat    = track_lat + longint'($urandom_range(200)) - 100;
    track_height = track_height + longint'($urandom_range(2000)) - 1000;
    if (pick < 6) begin
      f.lon    = COORD_W'(track_lon + longint'($urandom_range(20000)) - 10000);
      f.lat    = LAT_W'(track_lat + longint'($urandom_range(20000)) - 10000);
      f.height = COORD_W'(track_height + longint'($urandom_range(10000)) - 5000);
    end else if (pick < 8) begin
      f.lon    = COORD_W'(longint'($urandom_range(32'd3600000000)) - 64'sd1800000000);
      f.lat    = LAT_W'(longint'($urandom_range(32'd1800000000)) - 64'sd900000000);
      f.height = $urandom();
    end else begin
      f.lon    = $urandom();
      f.lat    = LAT_W'($urandom());
      f.height = $urandom();
    end
    f.h_acc = random_acc();
    f.v_acc = random_acc();
    return f;
  endfunction

  task automatic offer_fix(input fix_t f);
    int unsigned gap;
    gap = 0;
    if (!steady_flow && $urandom_range(99) < 12)
      gap = ($urandom_range(9) == 0) ? $urandom_range(90, 20) : $urandom_range(6, 1);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    msg_id_i    <= f.id;
    lon_in_i    <= f.lon;
    lat_in_i    <= f.lat;
    height_in_i <= f.height;
    h_acc_in_i  <= f.h_acc;
    v_acc_in_i  <= f.v_acc;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
  endtask

  task automatic test_ignored_before_first();
    fix_t f;
    logic [ID_W-1:0] other_ids[4];
    other_ids[0] = ID_MIN;
    other_ids[1] = MSG_POS + 8'd1;
    other_ids[2] = MSG_PVT - 8'd1;
    other_ids[3] = ID_MAX;
    foreach (other_ids[i]) begin
      f    = random_fix();
      f.id = other_ids[i];
      offer_fix(f);
    end
  endtask

  task automatic test_first_fix();
    offer_fix(make_fix(MSG_POS, COORD_W'(track_lon), LAT_W'(track_lat),
                       COORD_W'(track_height), ACC_MAX, ACC_MAX));
  endtask

  task automatic test_field_extremes();
    offer_fix(make_fix(MSG_PVT, LON_MAX, LAT_MAX, HGT_MAX, 32'd1, 32'd1));
    offer_fix(make_fix(MSG_POS, LON_MIN, LAT_MIN, HGT_MIN, ACC_MAX, ACC_MAX));
    offer_fix(make_fix(ID_MAX, LON_MAX, LAT_MIN, HGT_MAX, ACC_MAX, 32'd0));
    offer_fix(make_fix(MSG_PVT, 32'sh8000_0000, 31'sh4000_0000, 32'sd0,
                       32'h5555_5555, 32'haaaa_aaaa));
    offer_fix(make_fix(MSG_PVT, 32'sh7fff_ffff, 31'sh3fff_ffff, -32'sd1,
                       32'haaaa_aaaa, 32'h5555_5555));
    offer_fix(make_fix(MSG_POS, 32'sd0, 31'sd0, 32'sd0, 32'd1000, 32'd1000));
    offer_fix(make_fix(MSG_PVT + 8'd1, LON_MIN, LAT_MAX, HGT_MIN, 32'd0, 32'd0));
    offer_fix(make_fix(MSG_PVT, COORD_W'(track_lon), LAT_W'(track_lat),
                       COORD_W'(track_height), 32'd3000, 32'd3000));
  endtask

  task automatic test_random_fixes(input int unsigned count);
    repeat (count) offer_fix(random_fix());
  endtask

  task automatic test_steady_stream(input int unsigned count);
    steady_flow = 1'b1;
    repeat (count) offer_fix(random_fix());
    steady_flow = 1'b0;
  endtask

  // receiver holds off while fixes keep coming, input must back up
  task automatic test_output_hold_off(input int unsigned count);
    burst_reqs <= burst_reqs + 1;
    repeat (count) offer_fix(random_fix());
  endtask

  // zero new accuracy locks both channels, so this runs last
  task automatic test_zero_accuracy();
    offer_fix(make_fix(MSG_PVT, COORD_W'(track_lon), LAT_W'(track_lat),
                       COORD_W'(track_height), 32'd0, 32'd0));
    offer_fix(make_fix(MSG_POS, LON_MAX, LAT_MIN, HGT_MAX, 32'd0, 32'd0));
    offer_fix(make_fix(MSG_PVT, LON_MIN, LAT_MAX, HGT_MIN, ACC_MAX, ACC_MAX));
    offer_fix(make_fix(ID_MAX, LON_MAX, LAT_MAX, HGT_MAX, 32'd0, 32'd0));
    test_random_fixes(6);
  endtask

  initial begin
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    msg_id_i     <= '0;
    lon_in_i     <= '0;
    lat_in_i     <= '0;
    height_in_i  <= '0;
    h_acc_in_i   <= '0;
    v_acc_in_i   <= '0;
    track_lon    = longint'($urandom_range(32'd3000000000)) - 64'sd1500000000;
    track_lat    = longint'($urandom_range(32'd1600000000)) - 64'sd800000000;
    track_height = longint'($urandom_range(32'd2000000)) - 64'sd100000;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_ignored_before_first();
    test_first_fix();
    test_field_extremes();
    test_random_fixes(260);
    test_steady_stream(150);
    test_output_hold_off(30);
    test_zero_accuracy();

    in_valid_i <= 1'b0;
    while (pending_fusions.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
